// File: rtl/core/sbda_pkg.sv
// Shared constants for the signed binary to decimal ASCII converter.
package sbda_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int MAX_DIGITS_DEFAULT = 10;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

endpackage

// File: rtl/core/sbda_dabble.sv
// Bit-serial binary to BCD converter (shift and add three).
module sbda_dabble #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [sbda_pkg::VALUE_W-1:0]            magnitude,
  output logic                                    done,
  output logic [MAX_DIGITS*sbda_pkg::DIGIT_W-1:0] bcd
);
  import sbda_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;
  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd_adj;

  // Correct every digit before the shift; digits are independent.
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift one magnitude bit into the BCD register per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= magnitude;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
    end
  end

endmodule

// File: rtl/core/signed_binary_to_decimal_ascii.sv
// Top level: signed value to a stream of ASCII characters.
// Each accepted item is converted to text and sent out one character per
// transfer: an optional '-', then digit_count decimal digits (most
// significant first, leading zeros kept, higher digits dropped), with a '.'
// placed before the digit of weight 10^(dot_position-1); last marks the
// final digit. A digit_count of zero counts as one and values above
// MAX_DIGITS saturate. Before its first character, an item goes through the
// bit-serial BCD conversion (one magnitude bit per cycle through the
// shift-and-add-three register), then the registered done flag, then the
// step into the send phase; the characters then follow, held while out_ready
// is low. The input is taken only in the idle state, neither during a
// conversion nor while characters are sent; it is taken again while the
// final character still waits in the output register.
module signed_binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sbda_pkg::VALUE_W-1:0]   value,
  input  logic [sbda_pkg::COUNT_W-1:0]   digit_count,
  input  logic [sbda_pkg::COUNT_W-1:0]   dot_position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sbda_pkg::CHAR_W-1:0]    character,
  output logic                           last
);
  import sbda_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;
  localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CMP_W = COUNT_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic               neg;        // minus sign still to send
  logic               dot_sent;   // point already sent for current digit
  logic [POS_W-1:0]   pos;        // zero-based index of the next digit
  logic [COUNT_W-1:0] dot;
  logic               conv_start;
  logic               conv_done;
  logic [BCD_W-1:0]   bcd;
  logic [VALUE_W-1:0] magnitude;
  logic [POS_W-1:0]   pos_init;
  logic               slot_free;
  logic [DIGIT_W-1:0] digit;
  logic               dot_here;

  assign in_ready   = (state == ST_IDLE);
  assign conv_start = in_valid && in_ready;
  // Two's complement negate; the most negative value maps onto itself,
  // which read as unsigned is the right magnitude.
  assign magnitude  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
  assign slot_free  = !out_valid || out_ready;

  // Clamp the digit count into 1..MAX_DIGITS and keep it zero based.
  always_comb begin
    if (digit_count == '0) begin
      pos_init = '0;
    end else if (CMP_W'(digit_count) > CMP_W'(MAX_DIGITS)) begin
      pos_init = POS_W'(MAX_DIGITS - 1);
    end else begin
      pos_init = POS_W'(digit_count - COUNT_W'(1));
    end
  end

  assign digit    = bcd[{pos, 2'b00} +: DIGIT_W];
  assign dot_here = (CMP_W'(dot) == CMP_W'(pos) + CMP_W'(1)) && !dot_sent;

  sbda_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .start     (conv_start),
    .magnitude (magnitude),
    .done      (conv_done),
    .bcd       (bcd)
  );

  // Sequencer: wait for the conversion, then send sign, point and digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      neg      <= 1'b0;
      dot_sent <= 1'b0;
      pos      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (conv_start) begin
            state    <= ST_CONV;
            neg      <= value[VALUE_W-1];
            dot_sent <= 1'b0;
            pos      <= pos_init;
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (neg) begin
              neg <= 1'b0;
            end else if (dot_here) begin
              dot_sent <= 1'b1;
            end else begin
              dot_sent <= 1'b0;
              if (pos == '0) begin
                state <= ST_IDLE;
              end else begin
                pos <= pos - POS_W'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the point position with the item; it is payload only.
  always_ff @(posedge clk) begin
    if (conv_start) begin
      dot <= dot_position;
    end
  end

  // Output register: hold until transfer, load the next character when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      if (neg) begin
        character <= CH_MINUS;
        last      <= 1'b0;
      end else if (dot_here) begin
        character <= CH_POINT;
        last      <= 1'b0;
      end else begin
        character <= CH_ZERO + CHAR_W'(digit);
        last      <= (pos == '0);
      end
    end
  end

endmodule
